// ===== sv/lcmt_pkg.sv =====
// shared constants, widths and request codes of the li chao min line tree
package lcmt_pkg;

    localparam int LEAF_COUNT_DEF = 1024;

    localparam int SLOT_W  = 10;
    localparam int COORD_W = 31;
    localparam int SLOPE_W = 31;
    localparam int ICPT_IN_W = 61;
    localparam int RANGE_W = 11;
    localparam int X_W     = 33;
    localparam int ICPT_W  = 64;
    localparam int DA_W    = 32;
    localparam int DB_W    = 65;
    localparam int SUM_W   = 67;
    localparam int TDATA_IN_W  = 224;
    localparam int TDATA_OUT_W = 64;

    localparam logic signed [ICPT_W-1:0] EMPTY_Y = 64'sh4000_0000_0000_0000;
    localparam logic signed [X_W-1:0]    PAD_X   = 33'sh0_8000_0000;

    localparam logic [2:0] REQ_LOAD        = 3'd0;
    localparam logic [2:0] REQ_ADD_LINE    = 3'd1;
    localparam logic [2:0] REQ_ADD_SLOTS   = 3'd2;
    localparam logic [2:0] REQ_ADD_VALUES  = 3'd3;
    localparam logic [2:0] REQ_QUERY_SLOT  = 3'd4;
    localparam logic [2:0] REQ_QUERY_VALUE = 3'd5;

endpackage

// ===== sv/lcmt_eval_unit.sv =====
// shared multiply-add unit: registered (da * x), then sum with registered db
module lcmt_eval_unit (
    input  logic                                i_clk,
    input  logic signed [lcmt_pkg::DA_W-1:0]    i_da,
    input  logic signed [lcmt_pkg::X_W-1:0]     i_x,
    input  logic signed [lcmt_pkg::DB_W-1:0]    i_db,
    output logic signed [lcmt_pkg::SUM_W-1:0]   o_sum
);

    logic signed [lcmt_pkg::DA_W+lcmt_pkg::X_W-1:0] r_prod;
    logic signed [lcmt_pkg::DB_W-1:0]               r_db;

    always_ff @(posedge i_clk) begin
        r_prod <= i_da * i_x;
        r_db   <= i_db;
    end

    assign o_sum = lcmt_pkg::SUM_W'(r_prod) + lcmt_pkg::SUM_W'(r_db);

endmodule

// ===== sv/li_chao_min_line_tree_unit.sv =====
// li chao tree keeping the lower envelope of lines and segments over a coordinate table
//
// input channel (s_axis): one request per transfer, tuser carries the request kind,
// tdata the operands. output channel (m_axis): one 64-bit minimum per query.
// loads and adds give no output transfer; unknown kinds are dropped.
// the block takes one request at a time; tready is low while a request is worked.
// all line evaluations go through one multiplier followed by one adder.
// with TN = LEAF_COUNT rounded up to a power of two and L = log2(TN):
//   load: the coordinate is written as the request is taken
//   add line: one pass per visited node from the root down, at most L+1 nodes
//   add segment by slots: one line add per covering node, at most two
//     covering nodes per level
//   value operands first run a binary search of at most L+1 steps over the
//     coordinate table
//   query by slot: evaluates each node from leaf to root; query by value adds one search
// a finished result sits in an output register; the block takes the next request
// while it waits, and only a second query stalls until the first is taken.
// after reset the block runs a clearing pass over the node and
// coordinate memories and holds tready low until it is done.
module li_chao_min_line_tree_unit #(
    parameter int LEAF_COUNT = lcmt_pkg::LEAF_COUNT_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // slot_index, coord_value, slope, intercept, range_start, range_end,
    // value_start, value_end, zero pad
    input  logic [lcmt_pkg::TDATA_IN_W-1:0]      i_s_axis_tdata,
    // req_type
    input  logic [2:0]                           i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // min_value
    output logic [lcmt_pkg::TDATA_OUT_W-1:0]     o_m_axis_tdata
);

    localparam int AW = $clog2(LEAF_COUNT);
    localparam int TN = 1 << AW;
    localparam int NW = AW + 2;

    typedef enum logic [22:0] {
        S_CLEAR  = 23'b1 << 0,
        S_IDLE   = 23'b1 << 1,
        S_LB0    = 23'b1 << 2,
        S_LB1    = 23'b1 << 3,
        S_RINIT  = 23'b1 << 4,
        S_RTEST  = 23'b1 << 5,
        S_RLDONE = 23'b1 << 6,
        S_RRIGHT = 23'b1 << 7,
        S_RRDONE = 23'b1 << 8,
        S_RSHIFT = 23'b1 << 9,
        S_I0     = 23'b1 << 10,
        S_I1     = 23'b1 << 11,
        S_I2     = 23'b1 << 12,
        S_I3     = 23'b1 << 13,
        S_I4     = 23'b1 << 14,
        S_I5     = 23'b1 << 15,
        S_Q0     = 23'b1 << 16,
        S_Q1     = 23'b1 << 17,
        S_Q2     = 23'b1 << 18,
        S_Q3     = 23'b1 << 19,
        S_Q4     = 23'b1 << 20,
        S_QOUT   = 23'b1 << 21,
        S_SPARE  = 23'b1 << 22
    } t_state;

    typedef enum logic [1:0] {
        LB_VS = 2'd0,
        LB_VE = 2'd1,
        LB_Q  = 2'd2
    } t_lb_phase;

    // request fields
    logic [2:0]                                  w_req;
    logic [lcmt_pkg::SLOT_W-1:0]                 w_slot;
    logic signed [lcmt_pkg::COORD_W-1:0]         w_coord;
    logic signed [lcmt_pkg::SLOPE_W-1:0]         w_slope;
    logic signed [lcmt_pkg::ICPT_IN_W-1:0]       w_icpt;
    logic [lcmt_pkg::RANGE_W-1:0]                w_rs;
    logic [lcmt_pkg::RANGE_W-1:0]                w_re;
    logic signed [lcmt_pkg::COORD_W-1:0]         w_vs;
    logic signed [lcmt_pkg::COORD_W-1:0]         w_ve;

    assign w_req   = i_s_axis_tuser;
    assign w_slot  = i_s_axis_tdata[9:0];
    assign w_coord = i_s_axis_tdata[40:10];
    assign w_slope = i_s_axis_tdata[71:41];
    assign w_icpt  = i_s_axis_tdata[132:72];
    assign w_rs    = i_s_axis_tdata[143:133];
    assign w_re    = i_s_axis_tdata[154:144];
    assign w_vs    = i_s_axis_tdata[185:155];
    assign w_ve    = i_s_axis_tdata[216:186];

    // memories
    logic signed [lcmt_pkg::X_W-1:0]     coord_mem [TN];
    logic signed [lcmt_pkg::SLOPE_W-1:0] slope_mem [2*TN];
    logic signed [lcmt_pkg::ICPT_W-1:0]  icpt_mem  [2*TN];

    logic signed [lcmt_pkg::X_W-1:0]     r_coord_q;
    logic signed [lcmt_pkg::SLOPE_W-1:0] r_slope_q;
    logic signed [lcmt_pkg::ICPT_W-1:0]  r_icpt_q;

    logic [AW-1:0]                       coord_raddr;
    logic                                coord_we;
    logic [AW-1:0]                       coord_waddr;
    logic signed [lcmt_pkg::X_W-1:0]     coord_wdata;
    logic [AW:0]                         node_raddr;
    logic                                node_we;
    logic [AW:0]                         node_waddr;
    logic signed [lcmt_pkg::SLOPE_W-1:0] node_wslope;
    logic signed [lcmt_pkg::ICPT_W-1:0]  node_wicpt;

    // control and working registers
    t_state                              r_state;
    t_state                              r_ret;
    t_lb_phase                           r_phase;
    logic [AW:0]                         r_clr;
    logic                                r_out_valid;
    logic signed [lcmt_pkg::ICPT_W-1:0]  r_out_data;

    logic signed [lcmt_pkg::SLOPE_W-1:0] r_in_a;
    logic signed [lcmt_pkg::ICPT_W-1:0]  r_in_b;
    logic signed [lcmt_pkg::SLOPE_W-1:0] r_a;
    logic signed [lcmt_pkg::ICPT_W-1:0]  r_b;
    logic signed [lcmt_pkg::SLOPE_W-1:0] r_ka;
    logic signed [lcmt_pkg::ICPT_W-1:0]  r_kb;
    logic [NW-1:0]                       r_node;
    logic [AW:0]                         r_il;
    logic [AW:0]                         r_ir;
    logic                                r_ld;
    logic                                r_md;
    logic signed [lcmt_pkg::X_W-1:0]     r_x0;
    logic signed [lcmt_pkg::X_W-1:0]     r_x1;
    logic signed [lcmt_pkg::X_W-1:0]     r_x2;
    logic signed [lcmt_pkg::X_W-1:0]     r_xq;
    logic signed [lcmt_pkg::DA_W-1:0]    r_da;
    logic signed [lcmt_pkg::DB_W-1:0]    r_db;
    logic signed [lcmt_pkg::ICPT_W-1:0]  r_best;

    logic [AW:0]                         r_l;
    logic [AW:0]                         r_r;
    logic [NW-1:0]                       r_nl;
    logic [NW-1:0]                       r_nr;
    logic [NW-1:0]                       r_sz;

    logic signed [lcmt_pkg::COORD_W-1:0] r_key;
    logic signed [lcmt_pkg::COORD_W-1:0] r_key2;
    logic [AW:0]                         r_base;
    logic [AW:0]                         r_span;
    logic [AW-1:0]                       r_idx;

    // derived values
    logic                                in_take;
    logic                                out_take;
    logic                                out_load;
    logic [NW-1:0]                       m_full;
    logic [AW:0]                         mid;
    logic [AW:0]                         ir_m1;
    logic [AW:0]                         half;
    logic [AW:0]                         lb_addr;
    logic signed [lcmt_pkg::X_W-1:0]     unit_x;
    logic signed [lcmt_pkg::SUM_W-1:0]   unit_sum;
    logic                                sum_neg;
    logic                                ld_f;
    logic                                rd_f;
    logic [NW-1:0]                       child;
    logic [AW:0]                         lb_sat;

    assign in_take  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_take = r_out_valid && i_m_axis_tready;
    assign out_load = (r_state == S_QOUT) && (!r_out_valid || i_m_axis_tready);
    assign m_full   = NW'(r_il) + NW'(r_ir);
    assign mid      = m_full[NW-1:1];
    assign ir_m1    = r_ir - (AW+1)'(1);
    assign half     = r_span >> 1;
    assign lb_addr  = r_base + half;
    assign sum_neg  = unit_sum[lcmt_pkg::SUM_W-1];
    assign ld_f     = r_md ? !r_ld : r_ld;
    assign rd_f     = r_md ? !sum_neg : sum_neg;
    assign child    = {r_node[NW-2:0], !ld_f};
    assign lb_sat   = (r_base >= (AW+1)'(TN)) ? (AW+1)'(TN - 1) : r_base;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    always_comb begin
        case (r_state)
            S_I2:    unit_x = r_x0;
            S_I3:    unit_x = r_x1;
            S_I4:    unit_x = r_x2;
            default: unit_x = r_xq;
        endcase
    end

    lcmt_eval_unit u_eval (
        .i_clk (i_clk),
        .i_da  (r_da),
        .i_x   (unit_x),
        .i_db  (r_db),
        .o_sum (unit_sum)
    );

    // memory port selection
    always_comb begin
        coord_raddr = '0;
        node_raddr  = '0;
        case (r_state)
            S_I0:    coord_raddr = r_il[AW-1:0];
            S_I1:    coord_raddr = mid[AW-1:0];
            S_I2:    coord_raddr = ir_m1[AW-1:0];
            S_LB0:   coord_raddr = lb_addr[AW-1:0];
            S_Q0:    coord_raddr = r_idx;
            default: coord_raddr = '0;
        endcase
        case (r_state)
            S_I0:    node_raddr = r_node[AW:0];
            S_Q1:    node_raddr = r_node[AW:0];
            S_Q4:    node_raddr = r_node[AW+1:1];
            default: node_raddr = '0;
        endcase

        coord_we    = 1'b0;
        coord_waddr = r_clr[AW-1:0];
        coord_wdata = lcmt_pkg::PAD_X;
        if (r_state == S_CLEAR) begin
            coord_we = (r_clr < (AW+1)'(TN));
        end else if (in_take && w_req == lcmt_pkg::REQ_LOAD && 32'(w_slot) < TN) begin
            coord_we    = 1'b1;
            coord_waddr = AW'(w_slot);
            coord_wdata = lcmt_pkg::X_W'(w_coord);
        end

        node_we     = 1'b0;
        node_waddr  = r_clr;
        node_wslope = '0;
        node_wicpt  = lcmt_pkg::EMPTY_Y;
        if (r_state == S_CLEAR) begin
            node_we = 1'b1;
        end else if (r_state == S_I5 && r_md) begin
            node_we     = 1'b1;
            node_waddr  = r_node[AW:0];
            node_wslope = r_a;
            node_wicpt  = r_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (coord_we) begin
            coord_mem[coord_waddr] <= coord_wdata;
        end
        r_coord_q <= coord_mem[coord_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            slope_mem[node_waddr] <= node_wslope;
            icpt_mem[node_waddr]  <= node_wicpt;
        end
        r_slope_q <= slope_mem[node_raddr];
        r_icpt_q  <= icpt_mem[node_raddr];
    end

    // output register: a new result may replace one that is taken in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
            r_out_data  <= r_best;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ret       <= S_IDLE;
            r_phase     <= LB_VS;
            r_clr       <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + (AW+1)'(1);
                    if (r_clr == (AW+1)'(2*TN - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_take) begin
                        r_in_a <= w_slope;
                        r_in_b <= lcmt_pkg::ICPT_W'(w_icpt);
                        case (w_req)
                            lcmt_pkg::REQ_ADD_LINE: begin
                                r_a     <= w_slope;
                                r_b     <= lcmt_pkg::ICPT_W'(w_icpt);
                                r_node  <= NW'(1);
                                r_il    <= '0;
                                r_ir    <= (AW+1)'(TN);
                                r_ret   <= S_IDLE;
                                r_state <= S_I0;
                            end
                            lcmt_pkg::REQ_ADD_SLOTS: begin
                                r_l <= (32'(w_rs) > TN) ? (AW+1)'(TN) : (AW+1)'(w_rs);
                                r_r <= (32'(w_re) > TN) ? (AW+1)'(TN) : (AW+1)'(w_re);
                                r_state <= S_RINIT;
                            end
                            lcmt_pkg::REQ_ADD_VALUES: begin
                                r_key   <= w_vs;
                                r_key2  <= w_ve;
                                r_base  <= '0;
                                r_span  <= (AW+1)'(TN);
                                r_phase <= LB_VS;
                                r_state <= S_LB0;
                            end
                            lcmt_pkg::REQ_QUERY_SLOT: begin
                                r_idx   <= (32'(w_slot) >= TN) ? AW'(TN - 1) : AW'(w_slot);
                                r_state <= S_Q0;
                            end
                            lcmt_pkg::REQ_QUERY_VALUE: begin
                                r_key   <= w_coord;
                                r_base  <= '0;
                                r_span  <= (AW+1)'(TN);
                                r_phase <= LB_Q;
                                r_state <= S_LB0;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                // lower bound search over the coordinate table
                S_LB0: begin
                    if (r_span == '0) begin
                        case (r_phase)
                            LB_VS: begin
                                r_l     <= r_base;
                                r_key   <= r_key2;
                                r_base  <= '0;
                                r_span  <= (AW+1)'(TN);
                                r_phase <= LB_VE;
                            end
                            LB_VE: begin
                                r_r     <= r_base;
                                r_state <= S_RINIT;
                            end
                            default: begin
                                r_idx   <= lb_sat[AW-1:0];
                                r_state <= S_Q0;
                            end
                        endcase
                    end else begin
                        r_state <= S_LB1;
                    end
                end
                S_LB1: begin
                    if (r_coord_q < lcmt_pkg::X_W'(r_key)) begin
                        r_base <= lb_addr + (AW+1)'(1);
                        r_span <= r_span - half - (AW+1)'(1);
                    end else begin
                        r_span <= half;
                    end
                    r_state <= S_LB0;
                end
                // segment split into covering nodes, bottom up
                S_RINIT: begin
                    r_nl    <= NW'(TN) + NW'(r_l);
                    r_nr    <= NW'(TN) + NW'(r_r);
                    r_sz    <= NW'(1);
                    r_state <= S_RTEST;
                end
                S_RTEST: begin
                    if (r_l < r_r) begin
                        if (r_nl[0]) begin
                            r_a     <= r_in_a;
                            r_b     <= r_in_b;
                            r_node  <= r_nl;
                            r_il    <= r_l;
                            r_ir    <= (AW+1)'(NW'(r_l) + r_sz);
                            r_ret   <= S_RLDONE;
                            r_state <= S_I0;
                        end else begin
                            r_state <= S_RRIGHT;
                        end
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_RLDONE: begin
                    r_nl    <= r_nl + NW'(1);
                    r_l     <= (AW+1)'(NW'(r_l) + r_sz);
                    r_state <= S_RRIGHT;
                end
                S_RRIGHT: begin
                    if (r_nr[0]) begin
                        r_a     <= r_in_a;
                        r_b     <= r_in_b;
                        r_node  <= r_nr - NW'(1);
                        r_il    <= (AW+1)'(NW'(r_r) - r_sz);
                        r_ir    <= r_r;
                        r_ret   <= S_RRDONE;
                        r_state <= S_I0;
                    end else begin
                        r_state <= S_RSHIFT;
                    end
                end
                S_RRDONE: begin
                    r_nr    <= r_nr - NW'(1);
                    r_r     <= (AW+1)'(NW'(r_r) - r_sz);
                    r_state <= S_RSHIFT;
                end
                S_RSHIFT: begin
                    r_nl    <= r_nl >> 1;
                    r_nr    <= r_nr >> 1;
                    r_sz    <= r_sz << 1;
                    r_state <= S_RTEST;
                end
                // line insertion, one node per pass
                S_I0: begin
                    r_state <= r_node[NW-1] ? r_ret : S_I1;
                end
                S_I1: begin
                    r_ka    <= r_slope_q;
                    r_kb    <= r_icpt_q;
                    r_da    <= lcmt_pkg::DA_W'(r_a) - lcmt_pkg::DA_W'(r_slope_q);
                    r_db    <= lcmt_pkg::DB_W'(r_b) - lcmt_pkg::DB_W'(r_icpt_q);
                    r_x0    <= r_coord_q;
                    r_state <= S_I2;
                end
                S_I2: begin
                    r_x1    <= r_coord_q;
                    r_state <= S_I3;
                end
                S_I3: begin
                    r_ld    <= sum_neg;
                    r_x2    <= r_coord_q;
                    r_state <= S_I4;
                end
                S_I4: begin
                    r_md    <= sum_neg;
                    r_state <= S_I5;
                end
                S_I5: begin
                    if (r_md) begin
                        r_a <= r_ka;
                        r_b <= r_kb;
                    end
                    if (ld_f == rd_f) begin
                        r_state <= r_ret;
                    end else begin
                        r_node <= child;
                        if (ld_f) begin
                            r_ir <= mid;
                        end else begin
                            r_il <= mid;
                        end
                        r_state <= child[NW-1] ? r_ret : S_I0;
                    end
                end
                // query walks from the leaf to the root
                S_Q0: begin
                    r_best  <= lcmt_pkg::EMPTY_Y;
                    r_node  <= NW'(TN) + NW'(r_idx);
                    r_state <= S_Q1;
                end
                S_Q1: begin
                    r_xq    <= r_coord_q;
                    r_state <= S_Q2;
                end
                S_Q2: begin
                    r_da    <= lcmt_pkg::DA_W'(r_slope_q);
                    r_db    <= lcmt_pkg::DB_W'(r_icpt_q);
                    r_state <= S_Q3;
                end
                S_Q3: begin
                    r_state <= S_Q4;
                end
                S_Q4: begin
                    if (unit_sum < lcmt_pkg::SUM_W'(r_best)) begin
                        r_best <= unit_sum[lcmt_pkg::ICPT_W-1:0];
                    end
                    if (r_node == NW'(1)) begin
                        r_state <= S_QOUT;
                    end else begin
                        r_node  <= r_node >> 1;
                        r_state <= S_Q2;
                    end
                end
                S_QOUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== verif/testbench.sv =====
// testbench for the li chao min line tree: random requests checked against a line-tree predictor
`timescale 1ns / 100ps

module testbench;

    localparam int TN = lcmt_pkg::LEAF_COUNT_DEF;
    localparam longint SPAN_X = 1953125;   // coordinate step that keeps slots sorted

    typedef struct {
        logic [2:0] kind;
        int         slot;
        longint     cv;
        longint     slope;
        longint     icpt;
        int         rs;
        int         re;
        longint     vs;
        longint     ve;
    } t_req;

    // envelope predictor and store of pending minima
    class t_envelope_board;
        longint coord[TN];
        longint nslope[2*TN];
        longint nicpt[2*TN];
        longint pending_min[$];
        int     errors;

        function new();
            foreach (coord[i]) coord[i] = longint'(lcmt_pkg::PAD_X);
            foreach (nslope[i]) begin
                nslope[i] = 0;
                nicpt[i]  = longint'(lcmt_pkg::EMPTY_Y);
            end
            errors = 0;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function int lower_slot(longint key);
            int base, span, half;
            base = 0;
            span = TN;
            while (span > 0) begin
                half = span / 2;
                if (coord[base+half] < key) begin
                    base += half + 1;
                    span -= half + 1;
                end else begin
                    span = half;
                end
            end
            return base;
        endfunction

        function void insert_at(longint a, longint b, int node, int l, int r);
            int m;
            longint ka, kb, xl, xm, xr;
            bit ld, md, rd;
            while (node < 2*TN) begin
                m  = (l + r) / 2;
                ka = nslope[node];
                kb = nicpt[node];
                xl = coord[l];
                xm = coord[m];
                xr = coord[r-1];
                ld = (a*xl + b) < (ka*xl + kb);
                md = (a*xm + b) < (ka*xm + kb);
                rd = (a*xr + b) < (ka*xr + kb);
                if (md) begin
                    nslope[node] = a;
                    nicpt[node]  = b;
                    a  = ka;
                    b  = kb;
                    ld = !ld;
                    rd = !rd;
                end
                if (ld == rd) return;
                if (ld) begin
                    node = node * 2;
                    r    = m;
                end else begin
                    node = node * 2 + 1;
                    l    = m;
                end
            end
        endfunction

        function void insert_range(longint a, longint b, int l, int r);
            int nl, nr, sz;
            nl = TN + l;
            nr = TN + r;
            sz = 1;
            while (l < r) begin
                if (nl % 2 == 1) begin
                    insert_at(a, b, nl, l, l + sz);
                    nl++;
                    l += sz;
                end
                if (nr % 2 == 1) begin
                    insert_at(a, b, nr - 1, r - sz, r);
                    nr--;
                    r -= sz;
                end
                nl /= 2;
                nr /= 2;
                sz *= 2;
            end
        endfunction

        function longint min_at(int idx);
            longint best, x, y;
            int node;
            if (idx >= TN) idx = TN - 1;
            best = longint'(lcmt_pkg::EMPTY_Y);
            x = coord[idx];
            for (node = idx + TN; node > 0; node /= 2) begin
                y = nslope[node] * x + nicpt[node];
                if (y < best) best = y;
            end
            return best;
        endfunction

        function void note_request(t_req q);
            int rs, re;
            case (q.kind)
                lcmt_pkg::REQ_LOAD: if (q.slot < TN) coord[q.slot] = q.cv;
                lcmt_pkg::REQ_ADD_LINE: insert_at(q.slope, q.icpt, 1, 0, TN);
                lcmt_pkg::REQ_ADD_SLOTS: begin
                    rs = (q.rs > TN) ? TN : q.rs;
                    re = (q.re > TN) ? TN : q.re;
                    insert_range(q.slope, q.icpt, rs, re);
                end
                lcmt_pkg::REQ_ADD_VALUES:
                    insert_range(q.slope, q.icpt, lower_slot(q.vs), lower_slot(q.ve));
                lcmt_pkg::REQ_QUERY_SLOT: pending_min.push_back(min_at(q.slot));
                lcmt_pkg::REQ_QUERY_VALUE: pending_min.push_back(min_at(lower_slot(q.cv)));
                default: ;
            endcase
        endfunction

        task check_min(logic [63:0] got);
            longint want;
            if (pending_min.size() == 0) begin
                report($sformatf("unexpected result %0d", $signed(got)));
            end else begin
                want = pending_min.pop_front();
                if ($signed(got) != want)
                    report($sformatf("min_value got %0d want %0d", $signed(got), want));
            end
        endtask
    endclass

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_s_axis_tvalid = 1'b0;
    logic                             o_s_axis_tready;
    logic [lcmt_pkg::TDATA_IN_W-1:0]  i_s_axis_tdata = '0;
    logic [2:0]                       i_s_axis_tuser = '0;
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready = 1'b0;
    logic [lcmt_pkg::TDATA_OUT_W-1:0] o_m_axis_tdata;

    t_envelope_board board = new();
    int send_idle_pct = 17;
    int recv_idle_pct = 80;

    li_chao_min_line_tree_unit DUT (.*);

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk)
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge i_clk)
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) board.check_min(o_m_axis_tdata);

    function automatic longint rand_val();
        return longint'($urandom_range(2000000000)) - 64'sd1000000000;
    endfunction

    function automatic longint rand_icpt();
        longint unsigned u;
        u = {$urandom, $urandom};
        return longint'(u % 64'd2000000000000000001) - 64'sd1000000000000000000;
    endfunction

    function automatic longint sorted_coord(int slot);
        return -64'sd1000000000 + slot * SPAN_X + $urandom_range(SPAN_X - 1);
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send(t_req q);
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= q.kind;
        i_s_axis_tdata  <= {7'b0, q.ve[30:0], q.vs[30:0], q.re[10:0], q.rs[10:0],
                            q.icpt[60:0], q.slope[30:0], q.cv[30:0], q.slot[9:0]};
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.note_request(q);
        @(negedge i_clk);
    endtask

    function automatic t_req mk(logic [2:0] kind);
        t_req q;
        q.kind  = kind;
        q.slot  = $urandom_range(TN - 1);
        q.cv    = rand_val();
        q.slope = rand_val();
        q.icpt  = rand_icpt();
        q.rs    = $urandom_range(TN);
        q.re    = $urandom_range(TN);
        q.vs    = rand_val();
        q.ve    = rand_val();
        return q;
    endfunction

    task automatic random_request();
        t_req q;
        int pick;
        pick = $urandom_range(99);
        if (pick < 18) begin
            q = mk(lcmt_pkg::REQ_LOAD);
            q.cv = sorted_coord(q.slot);
        end else if (pick < 21) begin
            q = mk(lcmt_pkg::REQ_LOAD);   // unsorted load
        end else if (pick < 34) begin
            q = mk(lcmt_pkg::REQ_ADD_LINE);
        end else if (pick < 48) begin
            q = mk(lcmt_pkg::REQ_ADD_SLOTS);
            if ($urandom_range(9) == 0) begin
                q.rs = $urandom_range(2047);
                q.re = $urandom_range(2047);
            end else if (q.rs > q.re) begin
                pick = q.rs; q.rs = q.re; q.re = pick;
            end
        end else if (pick < 62) begin
            q = mk(lcmt_pkg::REQ_ADD_VALUES);
            if (q.vs > q.ve && $urandom_range(4) != 0) begin
                q.cv = q.vs; q.vs = q.ve; q.ve = q.cv;
            end
        end else if (pick < 80) begin
            q = mk(lcmt_pkg::REQ_QUERY_SLOT);
        end else if (pick < 98) begin
            q = mk(lcmt_pkg::REQ_QUERY_VALUE);
        end else begin
            q = mk(3'($urandom_range(6, 7)));
        end
        send(q);
    endtask

    task automatic drain();
        while (board.pending_min.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    initial begin
        t_req q;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        send(mk(lcmt_pkg::REQ_QUERY_SLOT));   // empty tree
        for (int i = 0; i < 8; i++) begin
            q = mk(lcmt_pkg::REQ_LOAD);
            q.slot = i;
            q.cv = (i == 0) ? -64'sd1000000000 : sorted_coord(i);
            send(q);
        end
        q = mk(lcmt_pkg::REQ_LOAD); q.slot = TN - 1; q.cv = 64'sd1000000000; send(q);
        q = mk(lcmt_pkg::REQ_ADD_LINE); q.slope = 64'sd1000000000;
        q.icpt = 64'sd1000000000000000000;
        send(q);
        q = mk(lcmt_pkg::REQ_ADD_LINE); q.slope = -64'sd1000000000;
        q.icpt = -64'sd1000000000000000000;
        send(q);
        q = mk(lcmt_pkg::REQ_ADD_SLOTS); q.rs = 2047; q.re = 2047; send(q);   // clamped, empty
        q = mk(lcmt_pkg::REQ_ADD_SLOTS); q.rs = 5; q.re = 2; send(q);         // reversed range
        q = mk(lcmt_pkg::REQ_ADD_SLOTS); q.rs = 1; q.re = 2000; q.slope = 0;
        q.icpt = -64'sd1000000000000000000; send(q);
        q = mk(lcmt_pkg::REQ_ADD_VALUES); q.vs = -64'sd1000000000; q.ve = 64'sd1000000000;
        send(q);
        q = mk(lcmt_pkg::REQ_QUERY_SLOT); q.slot = 0; send(q);
        q = mk(lcmt_pkg::REQ_QUERY_SLOT); q.slot = TN - 1; send(q);
        q = mk(lcmt_pkg::REQ_QUERY_VALUE); q.cv = 64'sd1000000000; send(q);    // key at the top coordinate
        q = mk(lcmt_pkg::REQ_QUERY_VALUE); q.cv = -64'sd1000000000; send(q);
        send(mk(3'd6));
        send(mk(3'd7));
        send(mk(lcmt_pkg::REQ_QUERY_VALUE));

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 80 : 0;
            recv_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 17 : 0;
            for (int n = 0; n < 360; n++) random_request();
            i_s_axis_tvalid <= 1'b0;
            drain();   // sender holds off until all minima are out
        end

        if (board.errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial begin
        #100000000;
        $display("testbench: done, errors");
        $finish;
    end
endmodule
